### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define PCRD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("pcrd assertion failed");

// Expression must never be true out of reset.
`define PCRD_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("pcrd forbidden condition");

`endif

### rtl/pcrd_pkg.sv
`timescale 1ns / 1ps
package pcrd_pkg;
  localparam int CfgW   = 18;
  localparam int TanW   = 17;
  localparam int PixW   = 16;
  localparam int DirW   = 19;
  localparam int AddrW  = 5;
  localparam int OutMax = 262143;
  localparam int OutMin = -262144;

  localparam logic [2:0] RegFwdX = 3'd0;
  localparam logic [2:0] RegFwdY = 3'd1;
  localparam logic [2:0] RegFwdZ = 3'd2;
  localparam logic [2:0] RegUpX  = 3'd3;
  localparam logic [2:0] RegUpY  = 3'd4;
  localparam logic [2:0] RegUpZ  = 3'd5;
  localparam logic [2:0] RegTanX = 3'd6;
  localparam logic [2:0] RegTanY = 3'd7;

  typedef logic [CfgW-1:0] cfg_word_t;

  typedef struct packed {
    cfg_word_t [2:0] fwd;
    cfg_word_t [2:0] up;
  } vec_cfg_t;
endpackage

### rtl/pcrd_pix_if.sv
`timescale 1ns / 1ps
interface pcrd_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

### rtl/pcrd_dir_if.sv
`timescale 1ns / 1ps
interface pcrd_dir_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] dir_x;
  logic signed [18:0] dir_y;
  logic signed [18:0] dir_z;
  logic               degenerate;

  modport source (output valid, output dir_x, output dir_y, output dir_z,
                  output degenerate, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                  input degenerate, output ready);
endinterface

### rtl/pcrd_norm.sv
`timescale 1ns / 1ps
module pcrd_norm import pcrd_pkg::*; #(
  parameter int FRACTION_BITS = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_wr_i,
  input  vec_cfg_t                       vec_i,
  output logic                           busy_o,
  output logic                           deg_o,
  output logic [8:0][FRACTION_BITS+1:0]  nrm_o
);
  localparam int F   = FRACTION_BITS;
  localparam int MW  = (37 - F > CfgW) ? 37 - F : CfgW;
  localparam int SW  = MW + 1;
  localparam int PW  = 2 * SW;
  localparam int L2W = 2 * MW + 2;
  localparam int LW  = MW + 1;
  localparam int QB  = F + 1;
  localparam int NW  = MW + F + 1;
  localparam int IT  = MW + 1;
  localparam int NWD = F + 2;
  localparam int CTW = $clog2((IT > QB) ? IT : QB);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CROSS = 3'd1;
  localparam logic [2:0] ST_SQ    = 3'd2;
  localparam logic [2:0] ST_ZCHK  = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_DIVLD = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;

  localparam logic signed [PW:0] RndHalf = (PW+1)'(1) << (F - 1);

  logic [2:0]            state_q, state_d;
  logic [2:0]            step_q, step_d;
  logic [1:0]            vsel_q, vsel_d;
  logic [1:0]            csel_q, csel_d;
  logic [CTW-1:0]        cnt_q, cnt_d;
  logic                  deg_q, deg_d;
  logic signed [PW-1:0]  acc_q, acc_d;
  logic [L2W-1:0]        len2_q, len2_d;
  logic [L2W-1:0]        rem_q, rem_d;
  logic [L2W-1:0]        root_q, root_d;
  logic [L2W-1:0]        bit_q, bit_d;
  logic [LW-1:0]         len_q, len_d;
  logic [LW-1:0]         drem_q, drem_d;
  logic [QB-1:0]         num_q, num_d;
  logic [QB-1:0]         quo_q, quo_d;
  logic                  neg_q, neg_d;
  logic signed [SW-1:0]  c_q [3];
  logic signed [SW-1:0]  c_d [3];
  logic [8:0][NWD-1:0]   nrm_q, nrm_d;

  logic signed [SW-1:0]  f_ext [3];
  logic signed [SW-1:0]  u_ext [3];
  logic signed [SW-1:0]  ma, mb, cur;
  logic signed [PW-1:0]  prod;
  logic signed [PW:0]    diff;
  logic signed [PW:0]    rnd;
  logic [1:0]            j, i1, i2;
  logic [MW-1:0]         mag;
  logic [NW-1:0]         numer;
  logic [L2W-1:0]        sq_sum;
  logic [LW:0]           trial;
  logic [3:0]            widx;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      f_ext[k] = SW'($signed(vec_i.fwd[k]));
      u_ext[k] = SW'($signed(vec_i.up[k]));
    end
  end

  // component of the vector under normalization
  always_comb begin
    case (vsel_q)
      2'd0:    cur = f_ext[csel_q];
      2'd1:    cur = u_ext[csel_q];
      default: cur = c_q[csel_q];
    endcase
  end

  // cross component j = f[j+1]*u[j+2] - f[j+2]*u[j+1]
  assign j  = step_q[2:1];
  assign i1 = (j == 2'd2) ? 2'd0 : j + 2'd1;
  assign i2 = (j == 2'd0) ? 2'd2 : j - 2'd1;

  always_comb begin
    if (state_q == ST_CROSS) begin
      ma = step_q[0] ? f_ext[i2] : f_ext[i1];
      mb = step_q[0] ? u_ext[i1] : u_ext[i2];
    end else begin
      ma = cur;
      mb = cur;
    end
  end

  assign prod   = PW'(ma) * PW'(mb);
  assign diff   = (PW+1)'(acc_q) - (PW+1)'(prod);
  assign rnd    = (diff + RndHalf) >>> F;
  assign mag    = cur[SW-1] ? MW'(-cur) : MW'(cur);
  assign numer  = NW'({mag, {F{1'b0}}}) + NW'(len_q >> 1);
  assign sq_sum = root_q + bit_q;
  assign trial  = {drem_q, num_q[QB-1]};
  assign widx   = 4'(vsel_q) * 4'd3 + 4'(csel_q);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    vsel_d  = vsel_q;
    csel_d  = csel_q;
    cnt_d   = cnt_q;
    deg_d   = deg_q;
    acc_d   = acc_q;
    len2_d  = len2_q;
    rem_d   = rem_q;
    root_d  = root_q;
    bit_d   = bit_q;
    len_d   = len_q;
    drem_d  = drem_q;
    num_d   = num_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    c_d     = c_q;
    nrm_d   = nrm_q;

    unique case (state_q)
      ST_IDLE: ;
      ST_CROSS: begin
        if (!step_q[0]) begin
          acc_d = prod;
        end else begin
          c_d[j] = rnd[SW-1:0];
        end
        if (step_q == 3'd5) begin
          state_d = ST_SQ;
          vsel_d  = 2'd0;
          csel_d  = 2'd0;
          len2_d  = '0;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_SQ: begin
        len2_d = len2_q + L2W'(prod);
        if (csel_q == 2'd2) begin
          state_d = ST_ZCHK;
        end else begin
          csel_d = csel_q + 2'd1;
        end
      end
      ST_ZCHK: begin
        if (len2_q == '0) begin
          deg_d = 1'b1;
          if (vsel_q == 2'd2) begin
            state_d = ST_IDLE;
          end else begin
            vsel_d  = vsel_q + 2'd1;
            csel_d  = 2'd0;
            len2_d  = '0;
            state_d = ST_SQ;
          end
        end else begin
          rem_d   = len2_q;
          root_d  = '0;
          bit_d   = L2W'(1) << (L2W - 2);
          cnt_d   = CTW'(IT - 1);
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (rem_q >= sq_sum) begin
          rem_d  = rem_q - sq_sum;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (cnt_q == '0) begin
          len_d   = root_d[LW-1:0];
          csel_d  = 2'd0;
          state_d = ST_DIVLD;
        end else begin
          cnt_d = cnt_q - CTW'(1);
        end
      end
      ST_DIVLD: begin
        // quotient stays below 2^QB, so the top bits start as remainder
        drem_d  = LW'(numer[NW-1:QB]);
        num_d   = numer[QB-1:0];
        neg_d   = cur[SW-1];
        quo_d   = '0;
        cnt_d   = CTW'(QB - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (trial >= {1'b0, len_q}) begin
          drem_d = LW'(trial - {1'b0, len_q});
          quo_d  = {quo_q[QB-2:0], 1'b1};
        end else begin
          drem_d = LW'(trial);
          quo_d  = {quo_q[QB-2:0], 1'b0};
        end
        num_d = num_q << 1;
        if (cnt_q == '0) begin
          nrm_d[widx] = neg_q ? NWD'(-$signed({1'b0, quo_d}))
                              : NWD'($signed({1'b0, quo_d}));
          if (csel_q != 2'd2) begin
            csel_d  = csel_q + 2'd1;
            state_d = ST_DIVLD;
          end else if (vsel_q == 2'd2) begin
            state_d = ST_IDLE;
          end else begin
            vsel_d  = vsel_q + 2'd1;
            csel_d  = 2'd0;
            len2_d  = '0;
            state_d = ST_SQ;
          end
        end else begin
          cnt_d = cnt_q - CTW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // any register write reruns the whole pass
    if (cfg_wr_i) begin
      state_d = ST_CROSS;
      step_d  = 3'd0;
      deg_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CROSS;
      step_q  <= 3'd0;
      vsel_q  <= 2'd0;
      csel_q  <= 2'd0;
      cnt_q   <= '0;
      deg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      vsel_q  <= vsel_d;
      csel_q  <= csel_d;
      cnt_q   <= cnt_d;
      deg_q   <= deg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    len2_q <= len2_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    len_q  <= len_d;
    drem_q <= drem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    c_q    <= c_d;
    nrm_q  <= nrm_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign deg_o  = deg_q;
  assign nrm_o  = nrm_q;
endmodule

### rtl/pinhole_camera_ray_direction.sv
`timescale 1ns / 1ps
// Pinhole camera primary ray direction.
// pix_i takes one item per cycle while pix_i.ready is high, pixel_x/pixel_y
// as unsigned fractions. dir_o returns the unnormalized ray direction
// (Q(18-F).F, Q4.14 at F = 14) and a degenerate flag; when forward, up or
// their cross product has zero length the direction is zero and degenerate is set.
// Camera vectors and half-FOV tangents are written over the APB port,
// register i at byte address 4*i; the user must write them only while no
// item is in flight, as the block itself does not enforce this.
// Four register stages carry one item per cycle while dir_o does not stall
// and no normalization pass runs.
// After reset and after every register write, a sequencer builds the
// right vector and normalizes all three vectors with one shared
// multiplier, a bit-serial square root and a bit-serial divider.
// pix_i.ready is low during that pass.
// When dir_o stalls, the pipeline fills its empty stages and then drops
// pix_i.ready; nothing is lost or repeated.
`include "assert_macros.svh"
module pinhole_camera_ray_direction import pcrd_pkg::*; #(
  parameter int FRACTION_BITS = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  pcrd_pix_if.sink         pix_i,
  pcrd_dir_if.source       dir_o
);
  localparam int F    = FRACTION_BITS;
  localparam int NWD  = F + 2;
  localparam int SXW  = F + 2;
  localparam int P1W  = SXW + TanW + 1;
  localparam int AW   = 19;
  localparam int PRW  = NWD + AW;
  localparam int CPW  = ((F + 20 > 2 * F + 2) ? F + 20 : 2 * F + 2) + 2;
  localparam int DW   = CPW - F;

  localparam logic signed [SXW-1:0] SOne   = SXW'(1) << F;
  localparam logic signed [P1W-1:0] P1Half = P1W'(1) << (F - 1);
  localparam logic signed [CPW-1:0] CHalf  = CPW'(1) << (F - 1);
  localparam logic signed [DW-1:0]  DMax   = DW'(OutMax);
  localparam logic signed [DW-1:0]  DMin   = DW'(OutMin);

  // ---------------- configuration ----------------
  vec_cfg_t          vec_q;
  logic [TanW-1:0]   tan_x_q, tan_y_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q.fwd[0] <= '0;
      vec_q.fwd[1] <= CfgW'(16384);
      vec_q.fwd[2] <= '0;
      vec_q.up[0]  <= '0;
      vec_q.up[1]  <= '0;
      vec_q.up[2]  <= CfgW'(16384);
      tan_x_q      <= TanW'(11472);
      tan_y_q      <= TanW'(11472);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        RegFwdX: vec_q.fwd[0] <= pwdata[CfgW-1:0];
        RegFwdY: vec_q.fwd[1] <= pwdata[CfgW-1:0];
        RegFwdZ: vec_q.fwd[2] <= pwdata[CfgW-1:0];
        RegUpX:  vec_q.up[0]  <= pwdata[CfgW-1:0];
        RegUpY:  vec_q.up[1]  <= pwdata[CfgW-1:0];
        RegUpZ:  vec_q.up[2]  <= pwdata[CfgW-1:0];
        RegTanX: tan_x_q      <= pwdata[TanW-1:0];
        RegTanY: tan_y_q      <= pwdata[TanW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegFwdX: prdata = 32'(vec_q.fwd[0]);
      RegFwdY: prdata = 32'(vec_q.fwd[1]);
      RegFwdZ: prdata = 32'(vec_q.fwd[2]);
      RegUpX:  prdata = 32'(vec_q.up[0]);
      RegUpY:  prdata = 32'(vec_q.up[1]);
      RegUpZ:  prdata = 32'(vec_q.up[2]);
      RegTanX: prdata = 32'(tan_x_q);
      RegTanY: prdata = 32'(tan_y_q);
      default: prdata = '0;
    endcase
  end

  // ---------------- camera basis ----------------
  logic                  nrm_busy, nrm_deg;
  logic [8:0][NWD-1:0]   nrm;

  pcrd_norm #(.FRACTION_BITS(F)) u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .vec_i    (vec_q),
    .busy_o   (nrm_busy),
    .deg_o    (nrm_deg),
    .nrm_o    (nrm)
  );

  // ---------------- pixel pipeline ----------------
  logic                  v1_q, v2_q, v3_q, v4_q;
  logic                  rdy1, rdy2, rdy3, rdy4;
  logic signed [P1W-1:0] p1x_q, p1y_q;
  logic signed [AW-1:0]  a_q, b_q;
  logic signed [PRW-1:0] pr_q [3];
  logic signed [PRW-1:0] pu_q [3];
  logic signed [DirW-1:0] dir_q [3];
  logic                  deg4_q;

  logic [PixW+F:0]       sxw, syw;
  logic [F:0]            sxu, syu;
  logic signed [SXW-1:0] sx, sy;
  logic signed [P1W-1:0] ra, rb;
  logic signed [CPW-1:0] comp [3];
  logic signed [CPW-1:0] dfull [3];
  logic signed [DirW-1:0] dsat [3];

  assign rdy4 = !v4_q | dir_o.ready;
  assign rdy3 = !v3_q | rdy4;
  assign rdy2 = !v2_q | rdy3;
  assign rdy1 = !v1_q | rdy2;
  assign pix_i.ready = rdy1 & !nrm_busy;

  assign sxw = {pix_i.pixel_x, {(F+1){1'b0}}};
  assign syw = {pix_i.pixel_y, {(F+1){1'b0}}};
  assign sxu = sxw[PixW+F:PixW];
  assign syu = syw[PixW+F:PixW];
  assign sx  = $signed({1'b0, sxu}) - SOne;
  assign sy  = $signed({1'b0, syu}) - SOne;
  assign ra  = (p1x_q + P1Half) >>> F;
  assign rb  = (p1y_q + P1Half) >>> F;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      comp[k] = CPW'(pr_q[k]) + CPW'(pu_q[k])
              + (CPW'($signed(nrm[k])) <<< F);
      dfull[k] = (comp[k] + CHalf) >>> F;
      if (DW'(dfull[k]) > DMax) begin
        dsat[k] = DirW'(OutMax);
      end else if (DW'(dfull[k]) < DMin) begin
        dsat[k] = DirW'(OutMin);
      end else begin
        dsat[k] = dfull[k][DirW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pix_i.valid & pix_i.ready;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      p1x_q <= P1W'(sx) * P1W'($signed({1'b0, tan_x_q}));
      p1y_q <= P1W'(sy) * P1W'($signed({1'b0, tan_y_q}));
    end
    if (rdy2) begin
      a_q <= ra[AW-1:0];
      b_q <= rb[AW-1:0];
    end
    if (rdy3) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[k] <= PRW'($signed(nrm[6+k])) * PRW'(a_q);
        pu_q[k] <= PRW'($signed(nrm[3+k])) * PRW'(b_q);
      end
    end
    if (rdy4) begin
      deg4_q <= nrm_deg;
      for (int k = 0; k < 3; k++) begin
        dir_q[k] <= nrm_deg ? '0 : dsat[k];
      end
    end
  end

  assign dir_o.valid      = v4_q;
  assign dir_o.dir_x      = dir_q[0];
  assign dir_o.dir_y      = dir_q[1];
  assign dir_o.dir_z      = dir_q[2];
  assign dir_o.degenerate = deg4_q;

  `PCRD_NEVER(busy_blocks_input, clk_i, rst_ni, nrm_busy && pix_i.ready)
  `PCRD_ASSERT(degenerate_is_zero, clk_i, rst_ni, (v4_q && deg4_q) |-> (dir_q[0] == '0 && dir_q[1] == '0 && dir_q[2] == '0))
  `PCRD_ASSERT(stalled_result_kept, clk_i, rst_ni, (v4_q && !dir_o.ready) |=> v4_q)
endmodule

### tb/pinhole_camera_ray_direction_test.sv
`timescale 1ns / 1ps
module pinhole_camera_ray_direction_test;
  import pcrd_pkg::*;

  localparam int F = 14;

  typedef struct packed {
    logic signed [18:0] dx;
    logic signed [18:0] dy;
    logic signed [18:0] dz;
    logic               degen;
  } ray_t;

  // camera settings as the block should hold them
  class ray_scoreboard;
    logic [17:0] fwd [3];
    logic [17:0] up [3];
    logic [16:0] tanx, tany;
    ray_t        pending [$];
    int          errors;
    int          checked;

    function new();
      fwd = '{18'd0, 18'd16384, 18'd0};
      up = '{18'd0, 18'd0, 18'd16384};
      tanx = 17'd11472;
      tany = 17'd11472;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        RegFwdX: fwd[0] = val[17:0];
        RegFwdY: fwd[1] = val[17:0];
        RegFwdZ: fwd[2] = val[17:0];
        RegUpX: up[0] = val[17:0];
        RegUpY: up[1] = val[17:0];
        RegUpZ: up[2] = val[17:0];
        RegTanX: tanx = val[16:0];
        default: tany = val[16:0];
      endcase
    endfunction

    function longint round_frac(longint v);
      return (v + (64'sd1 <<< (F - 1))) >>> F;
    endfunction

    function bit to_unit(longint v [3], output longint u [3]);
      longint unsigned sq, len, r, b, m, q;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        m = v[i] < 0 ? -v[i] : v[i];
        sq += m * m;
      end
      if (sq == 0) return 0;
      r = 0;
      b = 64'd1 << 62;
      while (b > sq) b >>= 2;
      while (b != 0) begin
        if (sq >= r + b) begin
          sq -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      len = r;
      for (int i = 0; i < 3; i++) begin
        m = v[i] < 0 ? -v[i] : v[i];
        q = ((m << F) + len / 2) / len;
        u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function void note_pixel(logic [15:0] px, logic [15:0] py);
      longint f [3], u [3], c [3], fn [3], un [3], rn [3];
      longint sx, sy, a, b, d;
      ray_t r;
      bit ok;
      for (int i = 0; i < 3; i++) begin
        f[i] = longint'($signed(fwd[i]));
        u[i] = longint'($signed(up[i]));
      end
      c[0] = round_frac(f[1] * u[2] - f[2] * u[1]);
      c[1] = round_frac(f[2] * u[0] - f[0] * u[2]);
      c[2] = round_frac(f[0] * u[1] - f[1] * u[0]);
      ok = to_unit(f, fn);
      ok = to_unit(u, un) && ok;
      ok = to_unit(c, rn) && ok;
      r = '{19'sd0, 19'sd0, 19'sd0, 1'b1};
      if (ok) begin
        sx = ((longint'(px) << (F + 1)) >>> 16) - (64'sd1 <<< F);
        sy = ((longint'(py) << (F + 1)) >>> 16) - (64'sd1 <<< F);
        a = round_frac(sx * longint'(tanx));
        b = round_frac(sy * longint'(tany));
        r.degen = 0;
        for (int i = 0; i < 3; i++) begin
          d = round_frac(rn[i] * a + un[i] * b + fn[i] * (64'sd1 <<< F));
          if (d > OutMax) d = OutMax;
          if (d < OutMin) d = OutMin;
          if (i == 0) r.dx = d[18:0];
          else if (i == 1) r.dy = d[18:0];
          else r.dz = d[18:0];
        end
      end
      pending.push_back(r);
    endfunction

    function void check_ray(ray_t got);
      ray_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pcrd_pix_if pix ();
  pcrd_dir_if dir ();

  pinhole_camera_ray_direction DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pix_i(pix.sink), .dir_o(dir.source)
  );

  always #10 clk_i = ~clk_i;

  ray_scoreboard sb = new();
  bit idle_on = 1;
  bit stall_hold = 0;
  int idle_cycles = 0;
  int sent = 0;

  initial begin
    pix.valid = 0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    dir.ready = 0;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (dir.valid && dir.ready)
        sb.check_ray('{dir.dir_x, dir.dir_y, dir.dir_z, dir.degenerate});
      if (stall_hold) begin
        dir.ready <= 0;
      end else if (idle_cycles > 0) begin
        idle_cycles--;
        dir.ready <= 0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        idle_cycles = $urandom_range(1, 18) - 1;
        dir.ready <= 0;
      end else begin
        dir.ready <= 1;
      end
    end
  end

  int quiet = 0;
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (dir.valid && dir.ready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic send_pixel(logic [15:0] px, logic [15:0] py);
    int gap;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 18);
      pix.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1;
    pix.pixel_x <= px;
    pix.pixel_y <= py;
    do @(posedge clk_i); while (!pix.ready);
    sb.note_pixel(px, py);
    sent++;
  endtask

  task automatic drain();
    pix.valid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_cfg(bit extreme);
    for (int i = 0; i < 8; i++) begin
      logic [31:0] v;
      v = $urandom();
      if (extreme) v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : (i < 6 ? 32'h0002_0000
                                                                : 32'h0001_FFFF);
      else if (i < 6) v = $urandom_range(0, 1) ? $urandom_range(0, 40000) - 20000 : v;
      else if ($urandom_range(0, 1)) v = $urandom_range(0, 30000);
      cfg_write(i[2:0], v);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h8000, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'h5555, 16'hAAAA);
    send_pixel(16'h0001, 16'h7FFF);
    drain();
    // parallel forward and up: degenerate
    cfg_write(RegUpX, 0); cfg_write(RegUpY, 32'd16384); cfg_write(RegUpZ, 0);
    send_pixel(16'h1234, 16'h4321);
    drain();
    // zero forward
    cfg_write(RegFwdY, 0); cfg_write(RegUpZ, 32'd16384);
    send_pixel(16'hFFFF, 16'h0000);
    drain();
    // tiny cross product that rounds to zero
    cfg_write(RegFwdX, 1); cfg_write(RegFwdY, 0); cfg_write(RegFwdZ, 0);
    cfg_write(RegUpX, 0); cfg_write(RegUpY, 1); cfg_write(RegUpZ, 0);
    send_pixel(16'h8000, 16'h8000);
    drain();
    // extremes, saturation
    cfg_write(RegFwdX, 32'h0001_FFFF); cfg_write(RegFwdY, 32'h0002_0000);
    cfg_write(RegFwdZ, 32'hFFFF_FFFF); cfg_write(RegUpX, 32'hFFFF_FFFF);
    cfg_write(RegUpY, 32'h0001_FFFF); cfg_write(RegUpZ, 32'h0002_0000);
    cfg_write(RegTanX, 32'hFFFF_FFFF); cfg_write(RegTanY, 32'h0001_FFFF);
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000);
    drain();
    cfg_write(RegTanX, 0);
    send_pixel(16'hFFFF, 16'h8000);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      random_cfg(ph % 4 == 3);
      if (ph == 11) idle_on = 0;
      for (int k = 0; k < 135; k++) begin
        if (ph == 2 && k == 20) begin
          fork
            begin
              stall_hold = 1;
              repeat (300) @(posedge clk_i);
              stall_hold = 0;
            end
          join_none
        end
        if (ph == 5 && k == 60) begin
          pix.valid <= 0;
          while (sb.pending.size() != 0) @(posedge clk_i);
        end
        send_pixel($urandom(), $urandom());
      end
      drain();
    end

    $display("Covered %0d pixels over 12 random camera setups plus directed extremes,",
             sent);
    $display("degenerate cameras and saturation; %0d results checked.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/pcrd_pkg.sv
rtl/pcrd_pix_if.sv
rtl/pcrd_dir_if.sv
rtl/pcrd_norm.sv
rtl/pinhole_camera_ray_direction.sv
tb/pinhole_camera_ray_direction_test.sv
